### rtl/ipr_pkg.sv
// Shared constants, codes and control types for the insertion/promotion
// recency replacement block. No dependencies.
`timescale 1ns / 1ps

package ipr_pkg;

  // Fixed field widths of the request and result ports.
  localparam int OP_W       = 2;
  localparam int SET_W      = 10;
  localparam int WAY_W      = 4;
  localparam int MASK_W     = 16;
  localparam int POS_W      = 4;
  localparam int PROMO_W    = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  // Default geometry.
  localparam int DEF_WAYS     = 16;
  localparam int DEF_NUM_SETS = 1024;

  // Scaling of the reciprocal used to fold the set index into range.
  localparam int RECIP_SH = 20;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
  localparam logic [OP_W-1:0] OP_HIT        = 2'd1;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_VICTIM     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INSERT_POS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROMO_MAP  = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register a new request
    logic read;     // resolve the set address and read its order
    logic update;   // write back the new order and register the result
    logic clr_wr;   // write the identity order during the clearing pass
  } ipr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last; // clearing pass is at its last set
  } ipr_stat_t;

endpackage

### rtl/ipr_ctrl.sv
// Controller state machine for the recency replacement block.
// Depends on ipr_pkg for the command and status types.
`timescale 1ns / 1ps

module ipr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output ipr_pkg::ipr_cmd_t cmd,
  input  ipr_pkg::ipr_stat_t stat
);
  import ipr_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_ADDR  = 2'd2;
  localparam logic [1:0] S_UPD   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // A new request may enter while the previous one writes back.
  assign busy   = (state == S_CLEAR) || (state == S_ADDR);
  assign accept = start && !busy;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.capture = accept;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.read   = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = accept ? S_ADDR : S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_read_then_update: assert property (@(posedge clk) disable iff (rst)
    cmd.read |=> cmd.update)
    else $error("read not followed by update");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (busy && !cmd.update))
    else $error("block not clearing after reset");

  a_capture_leads_read: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.read)
    else $error("captured request not read");

endmodule

### rtl/ipr_dp.sv
// Datapath of the recency replacement block: request registers, set
// address folding, the order memory, the move and victim logic.
// Depends on ipr_pkg for widths, codes and command types.
`timescale 1ns / 1ps

module ipr_dp #(
  parameter int WAYS     = ipr_pkg::DEF_WAYS,
  parameter int NUM_SETS = ipr_pkg::DEF_NUM_SETS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ipr_pkg::ipr_cmd_t             cmd,
  output ipr_pkg::ipr_stat_t            stat,
  input  logic [ipr_pkg::OP_W-1:0]      operation,
  input  logic [ipr_pkg::SET_W-1:0]     set_index,
  input  logic [ipr_pkg::WAY_W-1:0]     way,
  input  logic [ipr_pkg::MASK_W-1:0]    candidate_mask,
  input  logic [ipr_pkg::POS_W-1:0]     insert_position,
  input  logic [ipr_pkg::PROMO_W-1:0]   promotion_map,
  output logic                          done,
  output logic [ipr_pkg::WAY_W-1:0]     victim_way,
  output logic                          victim_found,
  output logic [ipr_pkg::POS_W-1:0]     prior_position
);
  import ipr_pkg::*;

  localparam int ADDR_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WIDX_W  = $clog2(WAYS);
  localparam int NS_W    = $clog2(NUM_SETS + 1);
  localparam int RECIP   = (1 << RECIP_SH) / NUM_SETS;
  localparam int RECIP_W = RECIP_SH + 1;
  localparam int P1_W    = SET_W + RECIP_W;
  localparam int P2_W    = SET_W + NS_W;
  localparam logic [POS_W:0]   WAYS_X = (POS_W + 1)'(WAYS);
  localparam logic [POS_W-1:0] BOTTOM = POS_W'(WAYS - 1);

  typedef logic [WAYS-1:0][POS_W-1:0] order_t;

  order_t mem [NUM_SETS];

  // Request registers.
  logic [OP_W-1:0]   op_q;
  logic [SET_W-1:0]  set_q;
  logic [SET_W-1:0]  quot_q;
  logic [WAY_W-1:0]  way_q;
  logic [MASK_W-1:0] mask_q;

  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] clr_cnt;
  order_t            rd_word;

  logic [P1_W-1:0]   prod1;
  logic [P2_W-1:0]   prod2;
  logic [P2_W-1:0]   rem0;
  logic [P2_W-1:0]   rem;
  logic [ADDR_W-1:0] addr;

  order_t            ident;
  order_t            new_word;
  logic              way_ok;
  logic              do_write;
  logic [POS_W-1:0]  p;
  logic [POS_W-1:0]  raw;
  logic [POS_W-1:0]  q;
  logic [WAYS-1:0]   win;
  logic [WAY_W-1:0]  vw;
  logic              vf;

  // The set index is folded below NUM_SETS with a scaled reciprocal. The
  // estimated quotient is low by at most one, so one compare and subtract
  // finishes the remainder.
  assign prod1 = P1_W'(set_index) * P1_W'(RECIP);
  assign prod2 = P2_W'(quot_q) * P2_W'(NUM_SETS);
  assign rem0  = P2_W'(set_q) - prod2;
  assign rem   = (rem0 >= P2_W'(NUM_SETS)) ? rem0 - P2_W'(NUM_SETS) : rem0;
  assign addr  = rem[ADDR_W-1:0];

  assign stat.clr_last = (clr_cnt == ADDR_W'(NUM_SETS - 1));

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      ident[i] = POS_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= operation;
      set_q  <= set_index;
      quot_q <= prod1[RECIP_SH +: SET_W];
      way_q  <= way;
      mask_q <= candidate_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // Order memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt] <= ident;
    end else if (cmd.update && do_write) begin
      mem[addr_q] <= new_word;
    end
    if (cmd.read) begin
      rd_word <= mem[addr];
      addr_q  <= addr;
    end
  end

  // Move of the named way and shift of the ways between its old and new place.
  always_comb begin
    way_ok   = ({1'b0, way_q} < WAYS_X);
    p        = rd_word[way_q[WIDX_W-1:0]];
    unique case (op_q)
      OP_INSERT: raw = insert_position;
      OP_HIT:    raw = promotion_map[p * POS_W +: POS_W];
      default:   raw = BOTTOM;
    endcase
    q        = ({1'b0, raw} >= WAYS_X) ? BOTTOM : raw;
    do_write = way_ok && (op_q != OP_VICTIM);
    for (int i = 0; i < WAYS; i++) begin
      if (WIDX_W'(i) == way_q[WIDX_W-1:0]) begin
        new_word[i] = q;
      end else if (q < p && rd_word[i] >= q && rd_word[i] < p) begin
        new_word[i] = rd_word[i] + POS_W'(1);
      end else if (q > p && rd_word[i] > p && rd_word[i] <= q) begin
        new_word[i] = rd_word[i] - POS_W'(1);
      end else begin
        new_word[i] = rd_word[i];
      end
    end
  end

  // Victim: the candidate that no other candidate outranks in position.
  always_comb begin
    vw = '0;
    vf = |mask_q[WAYS-1:0];
    for (int i = 0; i < WAYS; i++) begin
      win[i] = mask_q[i];
      for (int j = 0; j < WAYS; j++) begin
        if (j != i && mask_q[j] && rd_word[j] > rd_word[i]) win[i] = 1'b0;
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (win[i]) vw = vw | WAY_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (op_q == OP_VICTIM) begin
        victim_way     <= vf ? vw : '0;
        victim_found   <= vf;
        prior_position <= '0;
      end else begin
        victim_way     <= '0;
        victim_found   <= 1'b0;
        prior_position <= way_ok ? p : '0;
      end
    end
  end

  a_done_from_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.update))
    else $error("result strobe without update");

  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_wr |-> !(cmd.update || cmd.read || cmd.capture))
    else $error("request activity during clearing pass");

  a_victim_no_position: assert property (@(posedge clk) disable iff (rst)
    (done && victim_found) |-> (prior_position == '0))
    else $error("victim result carries a position");

endmodule

### rtl/insertion_promotion_replacement.sv
// Top level of the insertion/promotion recency replacement block: holds the
// configuration registers and joins controller and datapath.
// Depends on ipr_pkg, ipr_ctrl and ipr_dp.
//
// Usage:
//   A request (operation, set_index, way, candidate_mask) is taken at a
//   rising edge where start is high and busy is low. Every request gives one
//   result on victim_way, victim_found and prior_position, marked by done for
//   exactly one cycle; the receiver cannot hold it off.
//   The request passes an address step and then a write-back step, and done
//   is registered from the write-back step. busy is high in the address step,
//   in which the set's order is read from the order memory, and a new
//   request is taken during the write-back of the previous one.
//   Configuration: cfg_write with cfg_index and cfg_data writes
//   insert_position or promotion_map; write only while idle.
//   Reset: rst is synchronous. After it, a clearing pass writes the identity
//   order into every set, one set per cycle, with busy high; configuration
//   writes are taken during the pass.
`timescale 1ns / 1ps

module insertion_promotion_replacement #(
  parameter int WAYS     = ipr_pkg::DEF_WAYS,
  parameter int NUM_SETS = ipr_pkg::DEF_NUM_SETS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [ipr_pkg::OP_W-1:0]        operation,
  input  logic [ipr_pkg::SET_W-1:0]       set_index,
  input  logic [ipr_pkg::WAY_W-1:0]       way,
  input  logic [ipr_pkg::MASK_W-1:0]      candidate_mask,
  output logic                            done,
  output logic [ipr_pkg::WAY_W-1:0]       victim_way,
  output logic                            victim_found,
  output logic [ipr_pkg::POS_W-1:0]       prior_position,
  input  logic                            cfg_write,
  input  logic [ipr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ipr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ipr_pkg::*;

  ipr_cmd_t  cmd;
  ipr_stat_t stat;

  // Configuration registers.
  logic [POS_W-1:0]   insert_position;
  logic [PROMO_W-1:0] promotion_map;

  // The index is one bit wide, so every write lands on one of the two
  // registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      insert_position <= '0;
      promotion_map   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INSERT_POS: insert_position <= cfg_data[POS_W-1:0];
        REG_PROMO_MAP:  promotion_map   <= cfg_data[PROMO_W-1:0];
        default:        insert_position <= insert_position;
      endcase
    end
  end

  // The controller sequences clearing, address and write-back steps.
  ipr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // The datapath owns the order memory and computes moves and victims.
  ipr_dp #(
    .WAYS     (WAYS),
    .NUM_SETS (NUM_SETS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .operation       (operation),
    .set_index       (set_index),
    .way             (way),
    .candidate_mask  (candidate_mask),
    .insert_position (insert_position),
    .promotion_map   (promotion_map),
    .done            (done),
    .victim_way      (victim_way),
    .victim_found    (victim_found),
    .prior_position  (prior_position)
  );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the insertion/promotion recency replacement block.
// Depends on ipr_pkg and insertion_promotion_replacement. A shadow copy of every
// set's recency order predicts each result; a monitor compares the results in order.
`timescale 1ns / 1ps

module tb;
  import ipr_pkg::*;

  localparam int WAYS = DEF_WAYS;
  localparam int NUM_SETS = DEF_NUM_SETS;
  // The result strobe follows the address and write-back steps after the accepting edge.
  localparam int RESULT_LATENCY = 3;
  // The run holds reset, the clearing pass, about 1k requests, some of them after
  // a gap, and several drains. The limit below is many times what all of that takes.
  localparam int CYCLE_LIMIT = 200000;
  // Way i at position i. Used as a promotion map, it leaves a hit way in place.
  localparam logic [63:0] IDENTITY_ORDER = 64'hFEDC_BA98_7654_3210;
  // A promotion map that moves a hit way up by one position, with 0 staying at 0.
  localparam logic [63:0] PROMOTE_ONE = 64'hEDCB_A987_6543_2100;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             victim_found;
    logic [POS_W-1:0] prior_position;
  } access_result_t;

  // All inputs have a known value from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [OP_W-1:0]       operation = '0;
  logic [SET_W-1:0]      set_index = '0;
  logic [WAY_W-1:0]      way = '0;
  logic [MASK_W-1:0]     candidate_mask = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  done;
  logic [WAY_W-1:0]      victim_way;
  logic                  victim_found;
  logic [POS_W-1:0]      prior_position;

  // This is the expected state of the block: the order of each set and both
  // registers, plus the results that have been predicted but have not come yet.
  logic [63:0]      recency_shadow [NUM_SETS];
  logic [POS_W-1:0] insert_pos_shadow;
  logic [63:0]      promo_map_shadow;
  access_result_t   pending_results[$];

  // Most random traffic goes to a few sets, so their orders get deeply permuted.
  logic [SET_W-1:0] hot_sets [8];

  int op_count [4];
  int empty_victims = 0;
  int results_checked = 0;
  int mismatches = 0;
  int settings_used = 0;
  int cycle_count = 0;

  insertion_promotion_replacement uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .set_index     (set_index),
    .way           (way),
    .candidate_mask(candidate_mask),
    .done          (done),
    .victim_way    (victim_way),
    .victim_found  (victim_found),
    .prior_position(prior_position),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // This computes the result of one request and applies its move to the shadow
  // order. A victim request only reads the order. The other operations take the
  // way from its old position p to a target q. The ways in between shift by one
  // position toward p to close the gap.
  function automatic access_result_t predict_access(logic [OP_W-1:0] op,
                                                    logic [SET_W-1:0] set_idx,
                                                    logic [WAY_W-1:0] w,
                                                    logic [MASK_W-1:0] mask);
    access_result_t res;
    logic [63:0] order;
    int p;
    int q;
    int r;
    int best_pos;
    bit found;
    res = '0;
    order = recency_shadow[set_idx % NUM_SETS];
    if (op == OP_VICTIM) begin
      found = 1'b0;
      best_pos = 0;
      for (int i = 0; i < WAYS; i++) begin
        if (mask[i]) begin
          r = order[4*i +: 4];
          if (!found || r > best_pos) begin
            found = 1'b1;
            best_pos = r;
            res.victim_way = WAY_W'(i);
          end
        end
      end
      res.victim_found = found;
      return res;
    end
    // A way beyond the configured count leaves the order as it is.
    if (w >= WAYS) return res;
    p = order[4*w +: 4];
    case (op)
      OP_INSERT: q = insert_pos_shadow;
      OP_HIT:    q = promo_map_shadow[4*p +: 4];
      default:   q = WAYS - 1;
    endcase
    // A target below the bottom of the order saturates at the bottom.
    if (q > WAYS - 1) q = WAYS - 1;
    for (int i = 0; i < WAYS; i++) begin
      r = order[4*i +: 4];
      if (i != w) begin
        if (q < p && r >= q && r < p) order[4*i +: 4] = 4'(r + 1);
        else if (q > p && r > p && r <= q) order[4*i +: 4] = 4'(r - 1);
      end
    end
    order[4*w +: 4] = 4'(q);
    recency_shadow[set_idx % NUM_SETS] = order;
    res.prior_position = POS_W'(p);
    return res;
  endfunction

  // This issues one request and holds it until busy is low at a rising edge.
  // The expectation is queued at that accepting edge. start stays high on return,
  // so the next request can follow it directly.
  task automatic send_access(logic [OP_W-1:0] op, logic [SET_W-1:0] set_idx,
                             logic [WAY_W-1:0] w, logic [MASK_W-1:0] mask);
    @(negedge clk);
    start = 1'b1;
    operation = op;
    set_index = set_idx;
    way = w;
    candidate_mask = mask;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_access(op, set_idx, w, mask));
    op_count[op]++;
    if (op == OP_VICTIM && mask == '0) empty_victims++;
  endtask

  // This idles the request side; n sets the length of the gap. Random data is driven on the fields
  // meanwhile, so that they are checked for being ignored while start is low.
  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      operation = OP_W'($urandom);
      set_index = SET_W'($urandom);
      way = WAY_W'($urandom);
      candidate_mask = MASK_W'($urandom);
    end
  endtask

  // This stops sending and waits until every predicted result has come.
  // Each request gives exactly one result, so the block is idle after that.
  task automatic wait_for_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      REG_INSERT_POS: insert_pos_shadow = data[POS_W-1:0];
      REG_PROMO_MAP:  promo_map_shadow = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // The block must be drained before both registers are reprogrammed.
  task automatic program_policy(logic [63:0] insert_data, logic [63:0] promo_data);
    wait_for_results();
    write_register(REG_INSERT_POS, insert_data);
    write_register(REG_PROMO_MAP, promo_data);
    settings_used++;
  endtask

  function automatic logic [MASK_W-1:0] random_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      5:       return MASK_W'($urandom & $urandom);
      default: return MASK_W'($urandom);
    endcase
  endfunction

  // This sends one random request, sometimes after a gap of random length made by hold_off.
  // Hits and inserts make up most of the traffic, so that the orders keep changing.
  task automatic send_random_access(int gap_pct);
    int pick;
    logic [OP_W-1:0] op;
    logic [SET_W-1:0] set_idx;
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct)
      hold_off($urandom_range(1, 11));
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_HIT;
    else if (pick < 60) op = OP_INSERT;
    else if (pick < 75) op = OP_INVALIDATE;
    else op = OP_VICTIM;
    if ($urandom_range(0, 3) != 0) set_idx = hot_sets[$urandom_range(0, 7)];
    else set_idx = SET_W'($urandom_range(0, NUM_SETS - 1));
    send_access(op, set_idx, WAY_W'($urandom_range(0, WAYS - 1)), random_mask());
  endtask

  // These requests reach the corner values of the fields and both register extremes.
  // They include an empty candidate set, a full one and a single candidate. They
  // move ways between the top and the bottom in both directions.
  task automatic test_directed();
    program_policy(64'd0, 64'd0);
    send_access(OP_VICTIM, '0, '0, '1);
    send_access(OP_VICTIM, LAST_SET, '1, '0);
    send_access(OP_VICTIM, SET_W'(5), '0, MASK_W'(1));
    send_access(OP_INSERT, '0, '1, '0);
    send_access(OP_VICTIM, '0, '0, '1);
    send_access(OP_HIT, '0, '1, '0);
    send_access(OP_INVALIDATE, '0, '1, '1);
    send_access(OP_INVALIDATE, LAST_SET, '0, '0);
    send_access(OP_HIT, LAST_SET, '0, '1);
    send_access(OP_VICTIM, LAST_SET, '0, 16'h8001);
    // With the insert position and every promotion target at the bottom, both
    // inserts and hits move ways downward.
    program_policy(64'd15, '1);
    send_access(OP_INSERT, SET_W'(512), WAY_W'(3), '0);
    send_access(OP_HIT, SET_W'(512), WAY_W'(7), '0);
    send_access(OP_HIT, SET_W'(512), WAY_W'(3), '0);
    send_access(OP_VICTIM, SET_W'(512), '0, 16'h0088);
    send_access(OP_VICTIM, SET_W'(512), '0, 16'h8000);
    send_access(OP_INVALIDATE, SET_W'(512), '1, '0);
  endtask

  // Runs random traffic under a series of register settings, which include the
  // extreme ones. Half of the blocks have gaps and half run back to back.
  task automatic test_config_sweep();
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: program_policy(64'd0, 64'd0);
        1: program_policy(64'd15, '1);
        2: program_policy(64'd0, IDENTITY_ORDER);
        3: program_policy(64'd15, 64'd0);
        4: program_policy(64'd8, PROMOTE_ONE);
        default: program_policy({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      repeat (40) send_random_access((s % 2) ? 25 : 0);
    end
  endtask

  // This is the main random phase. Blocks of 50 requests switch between gaps and
  // no gaps. Midway the sender stops until the block has delivered everything,
  // and then the registers get a new random setting.
  task automatic test_random_traffic();
    program_policy(64'(POS_W'($urandom)), {$urandom, $urandom});
    for (int n = 0; n < 600; n++) begin
      if (n == 300) program_policy(64'(POS_W'($urandom)), {$urandom, $urandom});
      send_random_access(((n / 50) % 2) ? 30 : 0);
    end
  endtask

  // The last part of the run has no idling at all.
  task automatic test_back_to_back();
    program_policy(64'd3, PROMOTE_ONE);
    repeat (150) send_random_access(0);
  endtask

  // Result monitor. A strobe is taken at the rising edge that ends its cycle.
  // It is checked against the oldest predicted result.
  always @(posedge clk) begin
    access_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with no pending request: way=%0d found=%0d prior=%0d",
                   victim_way, victim_found, prior_position);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (victim_way !== want.victim_way || victim_found !== want.victim_found ||
            prior_position !== want.prior_position) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected way=%0d found=%0d prior=%0d, got way=%0d found=%0d prior=%0d",
                     results_checked, want.victim_way, want.victim_found,
                     want.prior_position, victim_way, victim_found, prior_position);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results pending",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NUM_SETS; s++) recency_shadow[s] = IDENTITY_ORDER;
    insert_pos_shadow = '0;
    promo_map_shadow = '0;
    for (int i = 0; i < 4; i++) op_count[i] = 0;
    for (int i = 0; i < 8; i++) hot_sets[i] = SET_W'($urandom);
    hot_sets[0] = '0;
    hot_sets[1] = LAST_SET;

    // Reset is applied once. The clearing pass after it shows up as busy, and the
    // first request simply waits for it to end.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_config_sweep();
    test_random_traffic();
    test_back_to_back();
    wait_for_results();

    $display("Requests: %0d insert, %0d hit, %0d invalidate, %0d victim (%0d with no candidate)",
             op_count[OP_INSERT], op_count[OP_HIT], op_count[OP_INVALIDATE],
             op_count[OP_VICTIM], empty_victims);
    $display("%0d results checked under %0d register settings, %0d mismatches",
             results_checked, settings_used, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
